@@ design/tmsp_pkg.sv @@
// ----------------------------------------------------------------------------
// tmsp_pkg: shared types and constants
// Field widths, stream packing and operation codes for the pointer-chase block.
// ----------------------------------------------------------------------------
`default_nettype none

package tmsp_pkg;

    localparam int NODE_W      = 10;
    localparam int SLOT_FW     = 4;
    localparam int SUM_W       = 32;
    localparam int HOP_W       = 8;
    localparam int S_USER_W    = 1;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 48;

    localparam logic [HOP_W-1:0] HOP_RESET = 8'd8;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_PACKET = 1'b1;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [SUM_W-1:0]  sum_t;
    typedef logic [HOP_W-1:0]  hop_t;

    // Control from the sequencer to the compare unit.
    typedef struct packed {
        logic en;
        logic first;
    } cmp_ctrl_t;

endpackage

`default_nettype wire

@@ design/tmsp_mem.sv @@
// ----------------------------------------------------------------------------
// tmsp_mem: bucket table storage
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tmsp_mem #(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14,
    parameter int DATA_W = 10
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ design/tmsp_max_unit.sv @@
// ----------------------------------------------------------------------------
// tmsp_max_unit: running-maximum compare unit
// Takes one row entry per cycle and keeps the largest, first one on a tie.
// ----------------------------------------------------------------------------
`default_nettype none

module tmsp_max_unit (
    input  wire logic                aclk,
    input  wire tmsp_pkg::cmp_ctrl_t ctrl,
    input  wire tmsp_pkg::node_t     data,
    output tmsp_pkg::node_t          best_next
);

    import tmsp_pkg::*;

    node_t best_reg;

    always_comb begin
        best_next = best_reg;
        if (ctrl.en && (ctrl.first || (data > best_reg))) begin
            best_next = data;
        end
    end

    always_ff @(posedge aclk) begin
        best_reg <= best_next;
    end

endmodule

`default_nettype wire

@@ design/table_max_slot_pointer_chase.sv @@
// ----------------------------------------------------------------------------
// table_max_slot_pointer_chase: max-slot pointer chase over a bucket table
//
// Requests arrive on the s_ stream. With tuser low a request writes one table
// entry (bucket, slot, entry_value); such requests are taken one per cycle
// while the block is idle. With tuser high it starts a walk at packet_key: each
// hop reduces the node modulo BUCKETS, reads the node's row one slot per cycle
// through the single memory read port, and moves to the largest entry. The end
// node is added to a wrapping 32-bit total and one result (end_node, running_sum)
// is placed in the m_ output register.
// Each hop of a walk runs the reduce steps, the setup, the serial row read and
// the hop end, then the walk finishes. The reduce steps are the conditional
// subtract steps of the modulo unit (none for the default BUCKETS = 1024). The
// next request can be taken in the same cycle that the walk's result is shown.
// s_tready is low during a walk and while its finished result waits for an
// earlier one to leave the output register; a stalled receiver holds the
// block after its walk.
// The hop count register is written through cfg_valid/cfg_ready/cfg_data.
// Reset clears the total to zero, sets hop_count to 8 and empties the output;
// table contents are not cleared and must be written before being walked.
// ----------------------------------------------------------------------------
`default_nettype none

module table_max_slot_pointer_chase #(
    parameter int BUCKETS = 1024,
    parameter int SLOTS   = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // bucket[9:0], slot[13:10], entry_value[23:14], packet_key[33:24], zero fill
    input  wire logic [tmsp_pkg::S_TDATA_W-1:0]  s_tdata,
    // op[0]
    input  wire logic [tmsp_pkg::S_USER_W-1:0]   s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // end_node[9:0], running_sum[41:10], zero fill
    output logic      [tmsp_pkg::M_TDATA_W-1:0]  m_tdata,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [tmsp_pkg::HOP_W-1:0]      cfg_data
);

    import tmsp_pkg::*;

    function automatic int red_steps_f(input int b);
        int n;
        n = 0;
        for (int k = 0; k <= NODE_W; k++) begin
            if ((longint'(b) << k) < (longint'(1) << NODE_W)) begin
                n++;
            end
        end
        return n;
    endfunction

    localparam int DEPTH     = BUCKETS * SLOTS;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SC_W      = $clog2(SLOTS + 1);
    localparam int RED_STEPS = red_steps_f(BUCKETS);
    localparam int RC_W      = $clog2(RED_STEPS + 2);
    localparam int RED_INIT  = (RED_STEPS > 0) ? (BUCKETS << (RED_STEPS - 1)) : 0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SETUP,
        ST_HOP,
        ST_HOP_END,
        ST_FINISH
    } state_t;

    state_t            state_reg, state_next;
    hop_t              hop_count_reg, hop_count_next;
    hop_t              hops_left_reg, hops_left_next;
    node_t             node_reg, node_next;
    node_t             div_reg, div_next;
    logic [RC_W-1:0]   red_cnt_reg, red_cnt_next;
    logic [SC_W-1:0]   slot_cnt_reg, slot_cnt_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              rvld_reg, rvld_next;
    logic              rfirst_reg, rfirst_next;
    sum_t              sum_reg, sum_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    node_t             in_bucket, in_entry, in_key;
    logic [SLOT_FW-1:0] in_slot;
    logic              in_accept, wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr;
    node_t             rd_data, best_next;
    cmp_ctrl_t         cmp_ctrl;

    assign in_bucket = s_tdata[9:0];
    assign in_slot   = s_tdata[13:10];
    assign in_entry  = s_tdata[23:14];
    assign in_key    = s_tdata[33:24];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign wr_en   = in_accept && (s_tuser[0] == OP_LOAD)
                     && (32'(in_bucket) < 32'(BUCKETS)) && (32'(in_slot) < 32'(SLOTS));
    assign wr_addr = ADDR_W'(32'(in_bucket) * 32'(SLOTS) + 32'(in_slot));
    assign rd_en   = (state_reg == ST_HOP);

    assign cmp_ctrl.en    = rvld_reg;
    assign cmp_ctrl.first = rfirst_reg;

    tmsp_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (NODE_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_entry),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    tmsp_max_unit u_max (
        .aclk      (aclk),
        .ctrl      (cmp_ctrl),
        .data      (rd_data),
        .best_next (best_next)
    );

    always_comb begin
        state_next     = state_reg;
        hop_count_next = hop_count_reg;
        hops_left_next = hops_left_reg;
        node_next      = node_reg;
        div_next       = div_reg;
        red_cnt_next   = red_cnt_reg;
        slot_cnt_next  = slot_cnt_reg;
        addr_next      = addr_reg;
        rvld_next      = rd_en;
        rfirst_next    = rd_en && (slot_cnt_reg == '0);
        sum_next       = sum_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;

        if (cfg_valid && cfg_ready) begin
            hop_count_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept && (s_tuser[0] == OP_PACKET)) begin
                    node_next      = in_key;
                    hops_left_next = hop_count_reg;
                    div_next       = NODE_W'(RED_INIT);
                    red_cnt_next   = RC_W'(RED_STEPS);
                    if (hop_count_reg == '0) begin
                        state_next = ST_FINISH;
                    end else if (RED_STEPS > 0) begin
                        state_next = ST_REDUCE;
                    end else begin
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_REDUCE: begin
                if (node_reg >= div_reg) begin
                    node_next = node_reg - div_reg;
                end
                div_next     = div_reg >> 1;
                red_cnt_next = red_cnt_reg - 1'b1;
                if (red_cnt_reg <= RC_W'(1)) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                addr_next     = ADDR_W'(32'(node_reg) * 32'(SLOTS));
                slot_cnt_next = '0;
                state_next    = ST_HOP;
            end
            ST_HOP: begin
                addr_next     = addr_reg + 1'b1;
                slot_cnt_next = slot_cnt_reg + 1'b1;
                if (slot_cnt_reg == SC_W'(SLOTS - 1)) begin
                    state_next = ST_HOP_END;
                end
            end
            ST_HOP_END: begin
                node_next      = best_next;
                hops_left_next = hops_left_reg - 1'b1;
                div_next       = NODE_W'(RED_INIT);
                red_cnt_next   = RC_W'(RED_STEPS);
                if (hops_left_reg == HOP_W'(1)) begin
                    state_next = ST_FINISH;
                end else if (RED_STEPS > 0) begin
                    state_next = ST_REDUCE;
                end else begin
                    state_next = ST_SETUP;
                end
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    sum_next      = sum_reg + SUM_W'(node_reg);
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {(M_TDATA_W - SUM_W - NODE_W)'(0), sum_next, node_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            hop_count_reg <= HOP_RESET;
            sum_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
            rvld_reg      <= 1'b0;
            rfirst_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            hop_count_reg <= hop_count_next;
            sum_reg       <= sum_next;
            m_tvalid_reg  <= m_tvalid_next;
            rvld_reg      <= rvld_next;
            rfirst_reg    <= rfirst_next;
        end
        hops_left_reg <= hops_left_next;
        node_reg      <= node_next;
        div_reg       <= div_next;
        red_cnt_reg   <= red_cnt_next;
        slot_cnt_reg  <= slot_cnt_next;
        addr_reg      <= addr_next;
        m_tdata_reg   <= m_tdata_next;
    end

endmodule

`default_nettype wire

@@ design/tmsp_checker.sv @@
// ----------------------------------------------------------------------------
// tmsp_checker: port-level assertions for the pointer-chase block
// Watches the stream and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tmsp_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [tmsp_pkg::S_USER_W-1:0]  s_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [tmsp_pkg::M_TDATA_W-1:0] m_tdata
);

    import tmsp_pkg::*;

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Result is valid right after reset.");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled result changed or was dropped.");

    a_walk_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == OP_PACKET) |=> !s_tready)
        else $error("Block took a request in the cycle after a walk began.");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == OP_LOAD) && !m_tvalid |=> !m_tvalid)
        else $error("A table write produced a result.");

    a_result_after_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("A result appeared without a walk in progress.");

endmodule

bind table_max_slot_pointer_chase tmsp_checker u_tmsp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ tb/table_max_slot_pointer_chase_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// table_max_slot_pointer_chase_tb: self-checking bench for the pointer chase
// Table writes and walk requests go in on the s_ stream with random gaps.
// Results are drained with random back-pressure. A local copy of the bucket
// table predicts the end node and running total for every walk. Walks are only
// started where every row they visit has been fully written. The hop count is
// changed between phases while the block is idle.
// ----------------------------------------------------------------------------

module table_max_slot_pointer_chase_tb;
    import tmsp_pkg::*;

    localparam int BUCKETS        = 1024;
    localparam int SLOTS          = 16;
    localparam int ANCHOR_ROW     = BUCKETS - 1;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        node_t end_node;
        sum_t  running_sum;
    } chase_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_USER_W-1:0]  s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [HOP_W-1:0]     cfg_data  = '0;

    node_t          bucket_rows [BUCKETS][SLOTS];
    logic [SLOTS-1:0] row_written [BUCKETS];
    int             full_rows[$];
    sum_t           end_total;
    hop_t           hop_setting;
    chase_result_t  pending_results[$];
    chase_result_t  want;
    int             mismatches;
    int             sent_items;
    int             quiet_cycles;
    int             ready_hold;
    bit             s_idle;
    bit             m_idle;

    table_max_slot_pointer_chase dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic node_t row_max(input node_t node);
        node_t best;
        best = bucket_rows[node][0];
        for (int s = 1; s < SLOTS; s++) begin
            if (bucket_rows[node][s] > best) begin
                best = bucket_rows[node][s];
            end
        end
        return best;
    endfunction

    function automatic bit walk_is_defined(input node_t key, input hop_t hops);
        node_t node;
        node = key;
        for (int h = 0; h < hops; h++) begin
            if (row_written[node] != '1) begin
                return 1'b0;
            end
            node = row_max(node);
        end
        return 1'b1;
    endfunction

    function automatic node_t walk_end(input node_t key, input hop_t hops);
        node_t node;
        node = key;
        for (int h = 0; h < hops; h++) begin
            node = row_max(node);
        end
        return node;
    endfunction

    function automatic node_t pick_full_row();
        return node_t'(full_rows[$urandom_range(0, full_rows.size() - 1)]);
    endfunction

    // The anchor row points at itself, so it is always a safe start.
    function automatic node_t pick_packet_key();
        node_t key;
        for (int t = 0; t < 8; t++) begin
            key = ($urandom_range(0, 3) == 0) ? node_t'($urandom_range(0, BUCKETS - 1))
                                              : pick_full_row();
            if (walk_is_defined(key, hop_setting)) begin
                return key;
            end
        end
        return node_t'(ANCHOR_ROW);
    endfunction

    task automatic send_request(input logic op, input node_t bucket, input logic [3:0] slot,
                                input node_t value, input node_t key);
        int    gap;
        node_t end_node;
        gap = s_idle ? $urandom_range(0, 11) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, key, value, slot, bucket};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_items++;
        if (op == OP_LOAD) begin
            bucket_rows[bucket][slot] = value;
            if (row_written[bucket] != '1) begin
                row_written[bucket][slot] = 1'b1;
                if (row_written[bucket] == '1) begin
                    full_rows.push_back(bucket);
                end
            end
        end else begin
            end_node  = walk_end(key, hop_setting);
            end_total = end_total + end_node;
            pending_results.push_back('{end_node, end_total});
        end
    endtask

    task automatic send_load(input node_t bucket, input logic [3:0] slot, input node_t value);
        send_request(OP_LOAD, bucket, slot, value, node_t'($urandom));
    endtask

    task automatic send_packet(input node_t key);
        send_request(OP_PACKET, node_t'($urandom), 4'($urandom), node_t'($urandom), key);
    endtask

    task automatic drain_requests();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_hop_count(input hop_t value);
        drain_requests();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        hop_setting = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // The row maximum normally names a fully written row and is put in two random slots, which may be the same one.
    task automatic fill_row(input node_t row);
        node_t top;
        node_t value;
        int    tie_a;
        int    tie_b;
        bit    noisy;
        top   = pick_full_row();
        noisy = ($urandom_range(0, 9) == 0);
        tie_a = $urandom_range(0, SLOTS - 1);
        tie_b = $urandom_range(0, SLOTS - 1);
        for (int s = 0; s < SLOTS; s++) begin
            if (noisy) begin
                value = node_t'($urandom_range(0, BUCKETS - 1));
            end else if (s == tie_a || s == tie_b) begin
                value = top;
            end else begin
                value = node_t'($urandom_range(0, top));
            end
            send_load(row, 4'(s), value);
        end
    endtask

    task automatic write_single_entry();
        node_t row;
        node_t value;
        row = node_t'($urandom_range(0, BUCKETS - 2));
        if ($urandom_range(0, 1) == 1) begin
            value = pick_full_row();
        end else if (row_written[row] == '1) begin
            value = node_t'($urandom_range(0, row_max(row)));
        end else begin
            value = node_t'($urandom_range(0, BUCKETS - 1));
        end
        send_load(row, 4'($urandom_range(0, SLOTS - 1)), value);
    endtask

    task automatic test_anchor_row();
        node_t pattern [SLOTS];
        pattern = '{10'd1023, 10'd0, 10'd1022, 10'h155, 10'h2AA, 10'd1, 10'd512, 10'd511,
                    10'd0, 10'd3, 10'd1000, 10'd7, 10'd256, 10'd1023, 10'd100, 10'd1023};
        for (int s = 0; s < SLOTS; s++) begin
            send_load(node_t'(ANCHOR_ROW), 4'(s), pattern[s]);
        end
        send_packet(node_t'(ANCHOR_ROW));
    endtask

    task automatic test_zero_hops();
        write_hop_count(8'd0);
        send_packet(10'd0);
        send_packet(10'd1023);
        send_packet(10'h155);
        send_packet(10'h2AA);
    endtask

    task automatic test_random_traffic(input int item_budget);
        hop_t hops;
        int   stop_at;
        int   pick;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    hops = 8'd3;
                end
                1: begin
                    hops = 8'd1;
                end
                2: begin
                    hops = hop_t'($urandom_range(0, 24));
                end
                3: begin
                    hops = 8'd8;
                end
                4: begin
                    hops = 8'd0;
                end
                5: begin
                    hops = hop_t'($urandom_range(2, 40));
                end
                6: begin
                    hops = 8'd5;
                end
                default: begin
                    hops = hop_t'($urandom_range(0, 15));
                end
            endcase
            write_hop_count(hops);
            s_idle  = ($urandom_range(0, 3) != 0);
            m_idle  = ($urandom_range(0, 3) != 0);
            stop_at = sent_items + item_budget / 8;
            if (phase == 0) begin
                fill_row(10'd0);
            end
            while (sent_items < stop_at) begin
                if ($urandom_range(0, 29) == 0) begin
                    s_idle = ~s_idle;
                end
                if ($urandom_range(0, 29) == 0) begin
                    m_idle = ~m_idle;
                end
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    fill_row(node_t'($urandom_range(0, BUCKETS - 2)));
                end else if (pick < 35) begin
                    write_single_entry();
                end else begin
                    send_packet(pick_packet_key());
                end
            end
        end
    endtask

    task automatic test_max_hops();
        write_hop_count(8'd255);
        repeat (4) begin
            send_packet(pick_packet_key());
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            ready_hold = m_idle ? $urandom_range(0, 11) : 0;
            if (pending_results.size() == 0) begin
                $error("result with no request waiting: end_node %0d, running_sum %0d",
                       m_tdata[9:0], m_tdata[41:10]);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[9:0] !== want.end_node) begin
                    $error("end_node mismatch: expected %0d, actual %0d",
                           want.end_node, m_tdata[9:0]);
                    mismatches++;
                end
                if (m_tdata[41:10] !== want.running_sum) begin
                    $error("running_sum mismatch: expected %0d, actual %0d",
                           want.running_sum, m_tdata[41:10]);
                    mismatches++;
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (ready_hold > 0) begin
            m_tready <= 1'b0;
            ready_hold--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("table_max_slot_pointer_chase test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        foreach (row_written[r]) begin
            row_written[r] = '0;
        end
        end_total    = '0;
        hop_setting  = HOP_RESET;
        mismatches   = 0;
        sent_items   = 0;
        quiet_cycles = 0;
        ready_hold   = 0;
        s_idle       = 1'b1;
        m_idle       = 1'b1;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_anchor_row();
        test_zero_hops();
        test_random_traffic(950);
        test_max_hops();

        drain_requests();
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("table_max_slot_pointer_chase test passed");
        end else begin
            $display("table_max_slot_pointer_chase test failed");
        end
        $finish;
    end

endmodule
